/* rtl/core/ssps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssps_pkg: shared types and constants of the speed supervision panel
// Mode codes, screen codes, lamp bit positions, register indexes and the
// structs that run between the sequencer parts.
// ---------------------------------------------------------------------------
package ssps_pkg;

    // Panel sequencer modes
    typedef enum logic [3:0] {
        MODE_OFF       = 4'd0,
        MODE_SCREEN1   = 4'd1,
        MODE_GAP       = 4'd2,
        MODE_SCREEN2   = 4'd3,
        MODE_ALLSEGS   = 4'd4,
        MODE_WAIT      = 4'd5,
        MODE_PRESSED   = 4'd6,
        MODE_SELFTEST  = 4'd7,
        MODE_RUNNING   = 4'd8,
        MODE_EMERGENCY = 4'd9
    } mode_t;

    // Shown message codes
    localparam logic [1:0] SCREEN_BLANK   = 2'd0;
    localparam logic [1:0] SCREEN_PA400   = 2'd1;
    localparam logic [1:0] SCREEN_UC512   = 2'd2;
    localparam logic [1:0] SCREEN_ALLSEGS = 2'd3;

    // Lamp bit positions in the lamp vector
    localparam int LAMP_MV    = 0;
    localparam int LAMP_FC    = 1;
    localparam int LAMP_OVER  = 2;
    localparam int LAMP_FU    = 3;
    localparam int LAMP_PE    = 4;
    localparam int LAMP_PS    = 5;
    localparam int LAMP_FAULT = 6;
    localparam int LAMP_BUZ   = 7;

    // All lamps and buzzer lit in self test (everything but fault)
    localparam logic [7:0] LAMP_TEST_MASK = 8'hBF;
    // Lamps kept when the key is locked (buzzer only)
    localparam logic [7:0] LAMP_KEEP_MASK = 8'h80;

    // Configuration register indexes
    localparam logic [2:0] REG_FIRST_SCREEN  = 3'd0;
    localparam logic [2:0] REG_BLANK_GAP     = 3'd1;
    localparam logic [2:0] REG_SECOND_SCREEN = 3'd2;
    localparam logic [2:0] REG_ALL_SEGMENTS  = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS    = 3'd4;
    localparam logic [2:0] REG_SELF_TEST     = 3'd5;
    localparam logic [2:0] REG_WARN_MARGIN   = 3'd6;
    localparam logic [2:0] REG_BRAKE_MARGIN  = 3'd7;

    // Register reset values
    localparam logic [15:0] FIRST_SCREEN_RST  = 16'd2200;
    localparam logic [15:0] BLANK_GAP_RST     = 16'd2200;
    localparam logic [15:0] SECOND_SCREEN_RST = 16'd2000;
    localparam logic [15:0] ALL_SEGMENTS_RST  = 16'd3000;
    localparam logic [15:0] LONG_PRESS_RST    = 16'd2000;
    localparam logic [15:0] SELF_TEST_RST     = 16'd2000;
    localparam logic [7:0]  WARN_MARGIN_RST   = 8'd5;
    localparam logic [7:0]  BRAKE_MARGIN_RST  = 8'd10;

    // Saturation value of the elapsed-time counter
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    // Duty wave full scale (twice the peak percent) and self-test duty
    localparam int          DUTY_SCALE = 200;
    localparam logic [6:0]  DUTY_FULL  = 7'd100;

    typedef struct packed {
        logic [15:0] first_screen_ms;
        logic [15:0] blank_gap_ms;
        logic [15:0] second_screen_ms;
        logic [15:0] all_segments_ms;
        logic [15:0] long_press_ms;
        logic [15:0] self_test_ms;
        logic [7:0]  warn_margin_kmh;
        logic [7:0]  brake_margin_kmh;
    } cfg_t;

    typedef struct packed {
        logic       key_unlocked;
        logic [8:0] train_speed;
        logic [8:0] limit_kmh;
        logic       brake_active;
        logic       test_button;
        logic       validate_button;
        logic       fault_ack_button;
        logic       fault_ack_contact;
    } tick_t;

    typedef struct packed {
        logic [3:0] mode_code;
        logic [1:0] screen_code;
        logic [7:0] lamps;
        logic [6:0] validate_duty;
        logic       brake_trigger;
    } result_t;

    // Wave generator levels for the current tick
    typedef struct packed {
        logic       blink_on;
        logic [6:0] duty_wave;
    } wave_t;

endpackage : ssps_pkg
`default_nettype wire

/* rtl/core/speed_supervision_panel_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// speed_supervision_panel_sequencer_top: train panel mode sequencer
// Steps the panel modes once per millisecond tick and drives lamps, buzzer,
// message code, validation duty and the brake request pulse.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one tick per transfer (key, speed, limit, brake and button
//   levels); m_* returns exactly one result per tick, in order.
//   cfg_* writes the timeout and margin registers by index; cfg_ready is
//   always high. Write registers only while no tick is in flight.
// Path: a tick accepted by the input channel sits in the input register, is
//   evaluated by the sequencer and lands in the output register, from which
//   its result is offered.
// Throughput: one tick per cycle while the output is not stalled; the input
//   register and output register form a two-stage pipeline.
// Stall: while m_tready is low the result holds, the input register still
//   takes one more tick, and then s_tready drops until the output drains.
// Reset: all modes, waves and lamps clear, registers take their defaults,
//   and both channels come up empty.
// ---------------------------------------------------------------------------
module speed_supervision_panel_sequencer_top #(
    parameter int DUTY_PERIOD_MS  = 900,
    parameter int BLINK_PERIOD_MS = 333
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Tick input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] key_unlocked, [9:1] train_speed, [18:10] limit_kmh, [19] brake_active,
    // [20] test_button, [21] validate_button, [22] fault_ack_button,
    // [23] fault_ack_contact
    input  wire logic [23:0] s_tdata,
    // Result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] mode_code, [5:4] screen_code, [6] lamp_mv, [7] lamp_fc,
    // [8] lamp_overspeed, [9] lamp_fu, [10] lamp_pe, [11] lamp_ps,
    // [12] lamp_fault, [13] buzzer, [20:14] validate_duty, [21] brake_trigger,
    // [23:22] zero
    output logic [23:0]      m_tdata,
    // Register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic              in_valid_reg;
    ssps_pkg::tick_t   in_tick_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    ssps_pkg::result_t out_reg;
    ssps_pkg::result_t result;
    ssps_pkg::cfg_t    cfg;
    ssps_pkg::wave_t   wave;
    logic              advance;
    logic              in_take;

    // Pipeline handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_tick_reg.key_unlocked      <= s_tdata[0];
            in_tick_reg.train_speed       <= s_tdata[9:1];
            in_tick_reg.limit_kmh         <= s_tdata[18:10];
            in_tick_reg.brake_active      <= s_tdata[19];
            in_tick_reg.test_button       <= s_tdata[20];
            in_tick_reg.validate_button   <= s_tdata[21];
            in_tick_reg.fault_ack_button  <= s_tdata[22];
            in_tick_reg.fault_ack_contact <= s_tdata[23];
        end
    end

    ssps_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ssps_wave #(
        .DUTY_PERIOD_MS  (DUTY_PERIOD_MS),
        .BLINK_PERIOD_MS (BLINK_PERIOD_MS)
    ) u_wave (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .wave  (wave)
    );

    ssps_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (in_tick_reg),
        .cfg    (cfg),
        .wave   (wave),
        .result (result)
    );

    // Output register: load on advance, drop after the transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.brake_trigger, out_reg.validate_duty,
                       out_reg.lamps, out_reg.screen_code, out_reg.mode_code};

    // A brake pulse only leaves self test (to wait) or running (to emergency),
    // or lands in off when the key drops in the same tick
    a_trigger_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.brake_trigger) |->
            (out_reg.mode_code == ssps_pkg::MODE_WAIT ||
             out_reg.mode_code == ssps_pkg::MODE_EMERGENCY ||
             out_reg.mode_code == ssps_pkg::MODE_OFF))
        else $error("brake pulse in unexpected mode");

    // Duty never exceeds full scale
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.validate_duty <= ssps_pkg::DUTY_FULL))
        else $error("validation duty out of range");

    // Off mode always shows a blank screen
    a_off_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.mode_code == ssps_pkg::MODE_OFF) |->
            (out_reg.screen_code == ssps_pkg::SCREEN_BLANK))
        else $error("screen lit while off");

    // Input side stalls only behind a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");

endmodule : speed_supervision_panel_sequencer_top
`default_nettype wire

/* rtl/core/ssps_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssps_cfg: configuration register file
// Holds the screen timeouts, long-press and self-test times and the speed margins, written by index.
// ---------------------------------------------------------------------------
module ssps_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [2:0]    wr_index,
    input  wire logic [15:0]   wr_data,
    output ssps_pkg::cfg_t     cfg
);

    ssps_pkg::cfg_t cfg_reg;
    ssps_pkg::cfg_t cfg_next;

    // Decode the write index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                ssps_pkg::REG_FIRST_SCREEN:  cfg_next.first_screen_ms  = wr_data;
                ssps_pkg::REG_BLANK_GAP:     cfg_next.blank_gap_ms     = wr_data;
                ssps_pkg::REG_SECOND_SCREEN: cfg_next.second_screen_ms = wr_data;
                ssps_pkg::REG_ALL_SEGMENTS:  cfg_next.all_segments_ms  = wr_data;
                ssps_pkg::REG_LONG_PRESS:    cfg_next.long_press_ms    = wr_data;
                ssps_pkg::REG_SELF_TEST:     cfg_next.self_test_ms     = wr_data;
                ssps_pkg::REG_WARN_MARGIN:   cfg_next.warn_margin_kmh  = wr_data[7:0];
                ssps_pkg::REG_BRAKE_MARGIN:  cfg_next.brake_margin_kmh = wr_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_screen_ms  <= ssps_pkg::FIRST_SCREEN_RST;
            cfg_reg.blank_gap_ms     <= ssps_pkg::BLANK_GAP_RST;
            cfg_reg.second_screen_ms <= ssps_pkg::SECOND_SCREEN_RST;
            cfg_reg.all_segments_ms  <= ssps_pkg::ALL_SEGMENTS_RST;
            cfg_reg.long_press_ms    <= ssps_pkg::LONG_PRESS_RST;
            cfg_reg.self_test_ms     <= ssps_pkg::SELF_TEST_RST;
            cfg_reg.warn_margin_kmh  <= ssps_pkg::WARN_MARGIN_RST;
            cfg_reg.brake_margin_kmh <= ssps_pkg::BRAKE_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : ssps_cfg
`default_nettype wire

/* rtl/core/ssps_wave.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssps_wave: free-running blink square wave and duty triangle wave
// Both phases advance by one per tick. The triangle ramp 200*phase/period is
// tracked incrementally as quotient and remainder, so no divider is needed.
// ---------------------------------------------------------------------------
module ssps_wave #(
    parameter int DUTY_PERIOD_MS  = 900,
    parameter int BLINK_PERIOD_MS = 333
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    output ssps_pkg::wave_t wave
);

    localparam int DW = $clog2(DUTY_PERIOD_MS);
    localparam int BW = $clog2(BLINK_PERIOD_MS);
    localparam int STEP_Q = ssps_pkg::DUTY_SCALE / DUTY_PERIOD_MS;
    localparam int STEP_R = ssps_pkg::DUTY_SCALE % DUTY_PERIOD_MS;

    localparam logic [DW-1:0] DUTY_LAST  = DW'(DUTY_PERIOD_MS - 1);
    localparam logic [DW-1:0] DUTY_HALF  = DW'(DUTY_PERIOD_MS / 2);
    localparam logic [DW:0]   DUTY_P     = (DW+1)'(DUTY_PERIOD_MS);
    localparam logic [DW:0]   RAMP_R     = (DW+1)'(STEP_R);
    localparam logic [7:0]    RAMP_Q     = 8'(STEP_Q);
    localparam logic [7:0]    RAMP_SCALE = 8'(ssps_pkg::DUTY_SCALE);
    localparam logic [BW-1:0] BLINK_LAST = BW'(BLINK_PERIOD_MS - 1);
    localparam logic [BW-1:0] BLINK_HALF = BW'(BLINK_PERIOD_MS / 2);

    logic [DW-1:0] duty_phase_reg, duty_phase_next;
    logic [7:0]    ramp_reg, ramp_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [BW-1:0] blink_phase_reg, blink_phase_next;
    logic [DW:0]   rem_sum;
    logic [7:0]    fall;

    // Advance phases and the ramp quotient/remainder
    always_comb
    begin
        rem_sum = {1'b0, rem_reg} + RAMP_R;
        if (duty_phase_reg == DUTY_LAST)
        begin
            duty_phase_next = '0;
            ramp_next       = '0;
            rem_next        = '0;
        end
        else if (rem_sum >= DUTY_P)
        begin
            duty_phase_next = duty_phase_reg + DW'(1);
            ramp_next       = ramp_reg + RAMP_Q + 8'd1;
            rem_next        = DW'(rem_sum - DUTY_P);
        end
        else
        begin
            duty_phase_next = duty_phase_reg + DW'(1);
            ramp_next       = ramp_reg + RAMP_Q;
            rem_next        = rem_sum[DW-1:0];
        end
        blink_phase_next = (blink_phase_reg == BLINK_LAST) ? '0 : blink_phase_reg + BW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_phase_reg  <= '0;
            ramp_reg        <= '0;
            rem_reg         <= '0;
            blink_phase_reg <= '0;
        end
        else if (step)
        begin
            duty_phase_reg  <= duty_phase_next;
            ramp_reg        <= ramp_next;
            rem_reg         <= rem_next;
            blink_phase_reg <= blink_phase_next;
        end
    end

    // Fold the ramp into a triangle and compare the blink phase
    always_comb
    begin
        fall          = RAMP_SCALE - ramp_reg;
        wave.duty_wave = (duty_phase_reg <= DUTY_HALF) ? ramp_reg[6:0] : fall[6:0];
        wave.blink_on  = (blink_phase_reg > BLINK_HALF);
    end

endmodule : ssps_wave
`default_nettype wire

/* rtl/core/ssps_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssps_seq: panel mode sequencer
// Holds mode, elapsed time, wave enables, PWM, duty, lamps and screen, and
// forms one result per tick from the current state and the tick fields.
// ---------------------------------------------------------------------------
module ssps_seq (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  ssps_pkg::tick_t  tick,
    input  ssps_pkg::cfg_t   cfg,
    input  ssps_pkg::wave_t  wave,
    output ssps_pkg::result_t result
);

    ssps_pkg::mode_t mode_reg, mode_next;
    logic [16:0]     elapsed_reg, elapsed_next;
    logic            duty_en_reg, duty_en_next;
    logic            fault_en_reg, fault_en_next;
    logic            pwm_reg, pwm_next;
    logic [6:0]      duty_reg, duty_next;
    logic [7:0]      lamps_reg, lamps_next;
    logic [1:0]      screen_reg, screen_next;
    logic            trigger;
    logic            ack;
    logic [9:0]      warn_limit;
    logic [9:0]      brake_limit;

    // Mode state register and companions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ssps_pkg::MODE_OFF;
            elapsed_reg  <= '0;
            duty_en_reg  <= 1'b0;
            fault_en_reg <= 1'b0;
            pwm_reg      <= 1'b0;
            duty_reg     <= '0;
            lamps_reg    <= '0;
            screen_reg   <= ssps_pkg::SCREEN_BLANK;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            elapsed_reg  <= elapsed_next;
            duty_en_reg  <= duty_en_next;
            fault_en_reg <= fault_en_next;
            pwm_reg      <= pwm_next;
            duty_reg     <= duty_next;
            lamps_reg    <= lamps_next;
            screen_reg   <= screen_next;
        end
    end

    // Next state and result for one tick
    always_comb
    begin
        ack         = tick.fault_ack_button | tick.fault_ack_contact;
        warn_limit  = {1'b0, tick.limit_kmh} + {2'b00, cfg.warn_margin_kmh};
        brake_limit = {1'b0, tick.limit_kmh} + {2'b00, cfg.brake_margin_kmh};

        mode_next     = mode_reg;
        duty_en_next  = duty_en_reg;
        fault_en_next = fault_en_reg;
        pwm_next      = pwm_reg;
        duty_next     = duty_reg;
        lamps_next    = lamps_reg;
        screen_next   = screen_reg;
        trigger       = 1'b0;
        elapsed_next  = (elapsed_reg == ssps_pkg::ELAPSED_MAX) ? elapsed_reg
                                                               : elapsed_reg + 17'd1;

        unique case (mode_reg)
            ssps_pkg::MODE_OFF:
            begin
                screen_next = ssps_pkg::SCREEN_BLANK;
                if (tick.key_unlocked)
                begin
                    screen_next   = ssps_pkg::SCREEN_PA400;
                    fault_en_next = 1'b1;
                    mode_next     = ssps_pkg::MODE_SCREEN1;
                    elapsed_next  = '0;
                end
            end
            ssps_pkg::MODE_SCREEN1:
            begin
                if (elapsed_next > {1'b0, cfg.first_screen_ms})
                begin
                    screen_next                  = ssps_pkg::SCREEN_BLANK;
                    lamps_next[ssps_pkg::LAMP_PS] = 1'b1;
                    mode_next                    = ssps_pkg::MODE_GAP;
                    elapsed_next                 = '0;
                end
            end
            ssps_pkg::MODE_GAP:
            begin
                if (elapsed_next > {1'b0, cfg.blank_gap_ms})
                begin
                    screen_next                  = ssps_pkg::SCREEN_UC512;
                    lamps_next[ssps_pkg::LAMP_PS] = 1'b0;
                    mode_next                    = ssps_pkg::MODE_SCREEN2;
                    elapsed_next                 = '0;
                end
            end
            ssps_pkg::MODE_SCREEN2:
            begin
                if (elapsed_next > {1'b0, cfg.second_screen_ms})
                begin
                    screen_next                  = ssps_pkg::SCREEN_ALLSEGS;
                    lamps_next[ssps_pkg::LAMP_MV] = 1'b1;
                    lamps_next[ssps_pkg::LAMP_FC] = 1'b1;
                    pwm_next                     = 1'b1;
                    duty_en_next                 = 1'b1;
                    mode_next                    = ssps_pkg::MODE_ALLSEGS;
                    elapsed_next                 = '0;
                end
            end
            ssps_pkg::MODE_ALLSEGS:
            begin
                if (elapsed_next > {1'b0, cfg.all_segments_ms})
                begin
                    screen_next                  = ssps_pkg::SCREEN_BLANK;
                    lamps_next[ssps_pkg::LAMP_MV] = 1'b0;
                    lamps_next[ssps_pkg::LAMP_FC] = 1'b0;
                    mode_next                    = ssps_pkg::MODE_WAIT;
                    elapsed_next                 = '0;
                end
            end
            ssps_pkg::MODE_WAIT:
            begin
                if (tick.test_button)
                begin
                    mode_next    = ssps_pkg::MODE_PRESSED;
                    elapsed_next = '0;
                end
                if (tick.validate_button)
                begin
                    pwm_next     = 1'b0;
                    duty_en_next = 1'b0;
                end
                if (ack)
                begin
                    fault_en_next                   = 1'b0;
                    lamps_next[ssps_pkg::LAMP_FAULT] = 1'b0;
                end
                // Both waves stopped: go running, even over a test press
                if (!fault_en_next && !duty_en_next)
                begin
                    mode_next = ssps_pkg::MODE_RUNNING;
                end
            end
            ssps_pkg::MODE_PRESSED:
            begin
                if (!tick.test_button)
                begin
                    mode_next = ssps_pkg::MODE_WAIT;
                end
                else if (elapsed_next > {1'b0, cfg.long_press_ms})
                begin
                    duty_en_next = 1'b0;
                    duty_next    = ssps_pkg::DUTY_FULL;
                    lamps_next   = lamps_reg | ssps_pkg::LAMP_TEST_MASK;
                    mode_next    = ssps_pkg::MODE_SELFTEST;
                    elapsed_next = '0;
                end
            end
            ssps_pkg::MODE_SELFTEST:
            begin
                if (elapsed_next > {1'b0, cfg.self_test_ms})
                begin
                    duty_en_next = 1'b1;
                    lamps_next   = lamps_reg & ~ssps_pkg::LAMP_TEST_MASK;
                    trigger      = 1'b1;
                    mode_next    = ssps_pkg::MODE_WAIT;
                end
            end
            ssps_pkg::MODE_RUNNING:
            begin
                if ({1'b0, tick.train_speed} > brake_limit)
                begin
                    trigger   = 1'b1;
                    mode_next = ssps_pkg::MODE_EMERGENCY;
                end
            end
            ssps_pkg::MODE_EMERGENCY:
            begin
                if (!tick.brake_active)
                begin
                    mode_next = ssps_pkg::MODE_RUNNING;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // Key locked: drop everything but the buzzer
        if (!tick.key_unlocked)
        begin
            screen_next   = ssps_pkg::SCREEN_BLANK;
            pwm_next      = 1'b0;
            lamps_next    = lamps_next & ssps_pkg::LAMP_KEEP_MASK;
            duty_en_next  = 1'b0;
            fault_en_next = 1'b0;
            mode_next     = ssps_pkg::MODE_OFF;
        end

        // Wave-driven lamps and duty
        if (fault_en_next)
        begin
            lamps_next[ssps_pkg::LAMP_FAULT] = wave.blink_on;
        end
        if (duty_en_next)
        begin
            duty_next = wave.duty_wave;
        end
        if (mode_next != ssps_pkg::MODE_SELFTEST)
        begin
            lamps_next[ssps_pkg::LAMP_OVER] = ({1'b0, tick.train_speed} > warn_limit);
        end

        result.mode_code     = mode_next;
        result.screen_code   = screen_next;
        result.lamps         = lamps_next;
        result.validate_duty = pwm_next ? duty_next : 7'd0;
        result.brake_trigger = trigger;
    end

endmodule : ssps_seq
`default_nettype wire
